@@ rtl/core/civ_dt_pkg.sv @@
// shared types, constants and calendar tables for the civil date to epoch converter
`default_nettype none

package civ_dt_pkg;

    localparam int YearW   = 14;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int EpochW  = 39;

    localparam int ShiftW  = 15;
    localparam int ProdW   = 30;
    localparam int DaysW   = 24;
    localparam int DaysCalcW = 26;
    localparam int TodW    = 17;
    localparam int ScaledW = 40;
    localparam int SumW    = 41;

    // x / 100 == (x * Recip100) >> Recip100Shift for x below 43690
    localparam logic [14:0] Recip100      = 15'd20972;
    localparam int          Recip100Shift = 21;

    localparam logic [ShiftW-1:0]    YearsPerEra = 15'd400;
    localparam logic [DaysCalcW-1:0] DaysOffset  = 26'd865565;
    localparam logic signed [17:0]   SecsPerDay  = 18'sd86400;
    localparam logic [TodW-1:0]      SecsPerHour = 17'd3600;
    localparam logic [TodW-1:0]      SecsPerMin  = 17'd60;
    localparam logic signed [SumW-1:0] OutMax    = 41'sd274877906943;

    localparam logic [MonthW-1:0] MonthJan = 4'd1;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthMar = 4'd3;
    localparam logic [MonthW-1:0] MonthApr = 4'd4;
    localparam logic [MonthW-1:0] MonthMay = 4'd5;
    localparam logic [MonthW-1:0] MonthJun = 4'd6;
    localparam logic [MonthW-1:0] MonthJul = 4'd7;
    localparam logic [MonthW-1:0] MonthAug = 4'd8;
    localparam logic [MonthW-1:0] MonthSep = 4'd9;
    localparam logic [MonthW-1:0] MonthOct = 4'd10;
    localparam logic [MonthW-1:0] MonthNov = 4'd11;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    typedef struct packed {
        logic [ShiftW-1:0]  shifted;
        logic [ProdW-1:0]   prod_shifted;
        logic [ProdW-1:0]   prod_quarter;
        logic [ProdW-1:0]   prod_year;
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [MonthW-1:0]  month_idx;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } front_t;

    typedef struct packed {
        logic signed [DaysW-1:0] days;
        logic [TodW-1:0]         tod;
        logic                    bad;
    } days_t;

    typedef struct packed {
        logic signed [ScaledW-1:0] scaled;
        logic [TodW-1:0]           tod;
        logic                      bad;
    } scaled_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                  input logic leap);
        logic [DayW-1:0] len;
        case (month)
            MonthJan, MonthMar, MonthMay, MonthJul,
            MonthAug, MonthOct, MonthDec: len = 5'd31;
            MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
            MonthFeb: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the month in a year that starts in March
    function automatic logic [8:0] cum_days(input logic [MonthW-1:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:  d = 9'd0;
            4'd1:  d = 9'd31;
            4'd2:  d = 9'd61;
            4'd3:  d = 9'd92;
            4'd4:  d = 9'd122;
            4'd5:  d = 9'd153;
            4'd6:  d = 9'd184;
            4'd7:  d = 9'd214;
            4'd8:  d = 9'd245;
            4'd9:  d = 9'd275;
            4'd10: d = 9'd306;
            4'd11: d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/civ_dt_front.sv @@
// first stage: shifted year and reciprocal products for the divisions by 100
`default_nettype none

module civ_dt_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           up_valid,
    output logic                                up_ready,
    input  wire logic [civ_dt_pkg::YearW-1:0]   year,
    input  wire logic [civ_dt_pkg::MonthW-1:0]  month,
    input  wire logic [civ_dt_pkg::DayW-1:0]    day,
    input  wire logic [civ_dt_pkg::HourW-1:0]   hour,
    input  wire logic [civ_dt_pkg::MinuteW-1:0] minute,
    input  wire logic [civ_dt_pkg::SecondW-1:0] second,
    output logic                                dn_valid,
    input  wire logic                           dn_ready,
    output civ_dt_pkg::front_t                  dn_data
);

    logic                v_reg;
    civ_dt_pkg::front_t  data_reg;
    civ_dt_pkg::front_t  data_next;
    logic [civ_dt_pkg::ShiftW-1:0] shifted;
    logic [civ_dt_pkg::ShiftW-1:0] quarter;

    always_comb
    begin
        shifted = civ_dt_pkg::ShiftW'(year) + civ_dt_pkg::YearsPerEra
                  - ((month <= civ_dt_pkg::MonthFeb) ? 15'd1 : 15'd0);
        quarter = shifted >> 2;
        data_next.shifted      = shifted;
        data_next.prod_shifted = civ_dt_pkg::ProdW'(shifted)
                                 * civ_dt_pkg::ProdW'(civ_dt_pkg::Recip100);
        data_next.prod_quarter = civ_dt_pkg::ProdW'(quarter)
                                 * civ_dt_pkg::ProdW'(civ_dt_pkg::Recip100);
        data_next.prod_year    = civ_dt_pkg::ProdW'(year)
                                 * civ_dt_pkg::ProdW'(civ_dt_pkg::Recip100);
        data_next.year         = year;
        data_next.month        = month;
        data_next.month_idx    = (month > civ_dt_pkg::MonthFeb) ? month - 4'd3 : month + 4'd9;
        data_next.day          = day;
        data_next.hour         = hour;
        data_next.minute       = minute;
        data_next.second       = second;
    end

    assign up_ready = !v_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/civ_dt_days.sv @@
// second stage: leap year, day check, day count and time of day
`default_nettype none

module civ_dt_days (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                up_valid,
    output logic                     up_ready,
    input  wire civ_dt_pkg::front_t  up_data,
    output logic                     dn_valid,
    input  wire logic                dn_ready,
    output civ_dt_pkg::days_t        dn_data
);

    logic                v_reg;
    civ_dt_pkg::days_t   data_reg;
    civ_dt_pkg::days_t   data_next;
    logic [7:0]          cent_shifted;
    logic [5:0]          era_shifted;
    logic [7:0]          cent_year;
    logic [civ_dt_pkg::YearW-1:0] rem_year;
    logic                leap;
    logic [civ_dt_pkg::DayW-1:0] len;
    logic [civ_dt_pkg::DaysCalcW-1:0] days_w;

    always_comb
    begin
        cent_shifted = up_data.prod_shifted[civ_dt_pkg::Recip100Shift +: 8];
        era_shifted  = up_data.prod_quarter[civ_dt_pkg::Recip100Shift +: 6];
        cent_year    = up_data.prod_year[civ_dt_pkg::Recip100Shift +: 8];
        rem_year     = up_data.year - civ_dt_pkg::YearW'(cent_year) * 14'd100;
        leap = (up_data.year[1:0] == 2'b00)
               && ((rem_year != '0) || (cent_year[1:0] == 2'b00));
        len  = civ_dt_pkg::month_len(up_data.month, leap);
        days_w = civ_dt_pkg::DaysCalcW'(up_data.shifted) * 26'd365
                 + civ_dt_pkg::DaysCalcW'(up_data.shifted >> 2)
                 - civ_dt_pkg::DaysCalcW'(cent_shifted)
                 + civ_dt_pkg::DaysCalcW'(era_shifted)
                 + civ_dt_pkg::DaysCalcW'(civ_dt_pkg::cum_days(up_data.month_idx))
                 + civ_dt_pkg::DaysCalcW'(up_data.day) - 26'd1
                 - civ_dt_pkg::DaysOffset;
        data_next.days = $signed(days_w[civ_dt_pkg::DaysW-1:0]);
        data_next.tod  = civ_dt_pkg::TodW'(up_data.hour) * civ_dt_pkg::SecsPerHour
                         + civ_dt_pkg::TodW'(up_data.minute) * civ_dt_pkg::SecsPerMin
                         + civ_dt_pkg::TodW'(up_data.second);
        data_next.bad  = (up_data.day == '0) || (up_data.day > len);
    end

    assign up_ready = !v_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = v_reg;
    assign dn_data  = data_reg;

endmodule

`default_nettype wire

@@ rtl/core/civ_dt_scale.sv @@
// third and fourth stages: days to seconds, add time of day, saturate and output register
`default_nettype none

module civ_dt_scale (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire civ_dt_pkg::days_t             up_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [civ_dt_pkg::EpochW-1:0]      epoch_seconds,
    output logic                               status
);

    logic                   mul_v_reg;
    logic                   mul_ready;
    civ_dt_pkg::scaled_t    mul_reg;
    civ_dt_pkg::scaled_t    mul_next;
    logic signed [41:0]     prod_w;

    logic                   out_v_reg;
    logic [civ_dt_pkg::EpochW-1:0] epoch_reg;
    logic [civ_dt_pkg::EpochW-1:0] epoch_next;
    logic                   status_reg;
    logic signed [civ_dt_pkg::SumW-1:0] total;

    always_comb
    begin
        prod_w = up_data.days * civ_dt_pkg::SecsPerDay;
        mul_next.scaled = prod_w[civ_dt_pkg::ScaledW-1:0];
        mul_next.tod    = up_data.tod;
        mul_next.bad    = up_data.bad;
    end

    always_comb
    begin
        total = civ_dt_pkg::SumW'(mul_reg.scaled)
                + $signed({{(civ_dt_pkg::SumW-civ_dt_pkg::TodW){1'b0}}, mul_reg.tod});
        if (mul_reg.bad)
            epoch_next = '0;
        else if (total > civ_dt_pkg::OutMax)
            epoch_next = civ_dt_pkg::OutMax[civ_dt_pkg::EpochW-1:0];
        else
            epoch_next = total[civ_dt_pkg::EpochW-1:0];
    end

    assign mul_ready = !out_v_reg || out_ready;
    assign up_ready  = !mul_v_reg || mul_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (up_ready)
                mul_v_reg <= up_valid;
            if (mul_ready)
                out_v_reg <= mul_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            mul_reg <= mul_next;
        if (mul_ready && mul_v_reg)
        begin
            epoch_reg  <= epoch_next;
            status_reg <= mul_reg.bad;
        end
    end

    assign out_valid     = out_v_reg;
    assign epoch_seconds = epoch_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/civil_datetime_to_epoch_seconds.sv @@
// top level: civil date and time to signed seconds since 1970-01-01
// each transfer passes through the front, days, multiply and output registers in order
// throughput: one transfer per cycle while out_ready holds, set by the four-stage pipeline
// the day-to-seconds multiply sits alone in the third stage
// reset: rst_n asynchronous, clears all stage valid bits, no result pending
`default_nettype none

module civil_datetime_to_epoch_seconds (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [civ_dt_pkg::YearW-1:0]   year,
    input  wire logic [civ_dt_pkg::MonthW-1:0]  month,
    input  wire logic [civ_dt_pkg::DayW-1:0]    day,
    input  wire logic [civ_dt_pkg::HourW-1:0]   hour,
    input  wire logic [civ_dt_pkg::MinuteW-1:0] minute,
    input  wire logic [civ_dt_pkg::SecondW-1:0] second,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [civ_dt_pkg::EpochW-1:0]       epoch_seconds,
    output logic                                status
);

    logic                front_valid;
    logic                front_ready;
    civ_dt_pkg::front_t  front_data;
    logic                days_valid;
    logic                days_ready;
    civ_dt_pkg::days_t   days_data;

    civ_dt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .year     (year),
        .month    (month),
        .day      (day),
        .hour     (hour),
        .minute   (minute),
        .second   (second),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .dn_data  (front_data)
    );

    civ_dt_days u_days (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (front_valid),
        .up_ready (front_ready),
        .up_data  (front_data),
        .dn_valid (days_valid),
        .dn_ready (days_ready),
        .dn_data  (days_data)
    );

    civ_dt_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .up_valid      (days_valid),
        .up_ready      (days_ready),
        .up_data       (days_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .epoch_seconds (epoch_seconds),
        .status        (status)
    );

endmodule

`default_nettype wire

@@ rtl/core/civ_dt_checker.sv @@
// port-level checks for the civil date to epoch converter, bound to the top level
`default_nettype none

module civ_dt_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [civ_dt_pkg::EpochW-1:0]  epoch_seconds,
    input wire logic                           status
);

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(epoch_seconds) && $stable(status))
        else $error("result changed while stalled");

    // rejected dates carry zero seconds
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> epoch_seconds == '0)
        else $error("nonzero seconds with bad status");

    // no valid year lies before year zero
    a_lower_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> $signed(epoch_seconds) >= -39'sd62167219200)
        else $error("seconds below year zero");

    // a free-running sink never stalls the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

endmodule

bind civil_datetime_to_epoch_seconds civ_dt_checker u_civ_dt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .epoch_seconds (epoch_seconds),
    .status        (status)
);

`default_nettype wire
